>>> rtl/rbr_pkg.sv
// Shared widths, types and constant tables of the relative bearing and range block.
`default_nettype none
package rbr_pkg;

    // Coordinate width of the position fields
    localparam int COORD_BITS      = 24;
    // CORDIC steps done on the bearing (at most the table length)
    localparam int ATAN_ITERATIONS = 16;

    localparam int HEAD_W   = 16;
    localparam int TAG_W    = 16;
    localparam int RANGE_W  = 25;
    localparam int BEAR_W   = 16;
    localparam int MAXD_W   = 25;
    localparam int MAXD_RESET = 1000000;

    // Input packing, lowest bits first
    localparam int IN_W      = 6 * COORD_BITS + 2 * HEAD_W + TAG_W;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OFS_OX    = 0;
    localparam int OFS_OY    = OFS_OX + COORD_BITS;
    localparam int OFS_OZ    = OFS_OY + COORD_BITS;
    localparam int OFS_HX    = OFS_OZ + COORD_BITS;
    localparam int OFS_HY    = OFS_HX + HEAD_W;
    localparam int OFS_TX    = OFS_HY + HEAD_W;
    localparam int OFS_TY    = OFS_TX + COORD_BITS;
    localparam int OFS_TZ    = OFS_TY + COORD_BITS;
    localparam int OFS_TAG   = OFS_TZ + COORD_BITS;
    localparam int S_TUSER_W = 2;
    localparam int USR_HAS_ID = 0;
    localparam int USR_FOUND  = 1;

    // Output packing, lowest bits first
    localparam int OUT_W     = TAG_W + RANGE_W + BEAR_W;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Datapath widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int MAX2_W = 2 * MAXD_W;
    localparam int RAD_W  = 2 * RANGE_W;
    localparam int REM_W  = RANGE_W + 2;
    localparam int PROD_W = HEAD_W + DIFF_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int ROT_W  = DOT_W + 1;
    localparam int NORM_PRE  = 30;
    localparam int NORM_W    = ROT_W + NORM_PRE;
    localparam int NORM_STEPS = 6;
    localparam int CW     = 36;
    localparam int ZW     = 28;
    localparam int ANGLE_SCALE_LOG = 12;

    localparam int ATAN_TABLE_LEN = 24;
    localparam int CORDIC_STEPS = (ATAN_ITERATIONS < ATAN_TABLE_LEN) ?
                                  ATAN_ITERATIONS : ATAN_TABLE_LEN;

    // Latencies after the front stages
    localparam int SQRT_LAT  = RANGE_W;
    localparam int ANGLE_LAT = 1 + NORM_STEPS + CORDIC_STEPS + 1;
    localparam int BACK_LAT  = (SQRT_LAT > ANGLE_LAT) ? SQRT_LAT : ANGLE_LAT;
    localparam int SQRT_PAD  = BACK_LAT - SQRT_LAT;
    localparam int ANGLE_PAD = BACK_LAT - ANGLE_LAT;
    localparam int FRONT_LAT = 4;

    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(9000 * 4096);
    localparam logic signed [ZW-1:0] Z_ROUND   = ZW'(2048);
    localparam logic signed [BEAR_W-1:0] BEAR_MAX = BEAR_W'(18000);
    localparam logic signed [BEAR_W-1:0] BEAR_MIN = -BEAR_W'(18000);

    typedef logic [ZW-1:0] atan_rom_t [ATAN_TABLE_LEN];
    localparam atan_rom_t ATAN_UNITS = '{
        ZW'(18432000), ZW'(10881045), ZW'(5749245), ZW'(2918407),
        ZW'(1464867),  ZW'(733147),   ZW'(366663),  ZW'(183343),
        ZW'(91673),    ZW'(45837),    ZW'(22918),   ZW'(11459),
        ZW'(5730),     ZW'(2865),     ZW'(1432),    ZW'(716),
        ZW'(358),      ZW'(179),      ZW'(90),      ZW'(45),
        ZW'(22),       ZW'(11),       ZW'(6),       ZW'(3)
    };

    // Shift of each normalising stage: 32, 16, 8, 4, 2, 1
    function automatic int norm_shift(input int j);
        norm_shift = 1 << (NORM_STEPS - 1 - j);
    endfunction

    // What travels alongside each item
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } rbr_ctrl_t;

    // Bearing operands leaving the front stages
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ZW-1:0]    z;
        logic                    zero;
    } rbr_vec_t;

endpackage
`default_nettype wire

>>> rtl/rbr_front.sv
// Front stages: offsets, products, sums, distance test and quadrant turn.
`default_nettype none
module rbr_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [rbr_pkg::S_TDATA_W-1:0] in_data,
    input  wire logic [rbr_pkg::S_TUSER_W-1:0] in_user,
    input  wire logic [rbr_pkg::MAXD_W-1:0]    max_distance,
    output rbr_pkg::rbr_ctrl_t                 out_ctrl,
    output logic [rbr_pkg::RAD_W-1:0]          out_rad,
    output rbr_pkg::rbr_vec_t                  out_vec
);
    import rbr_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [TAG_W-1:0] tag1_reg, tag2_reg, tag3_reg, tag4_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [HEAD_W-1:0] hx_reg, hy_reg;

    logic signed [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic signed [PROD_W-1:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    logic [MAX2_W-1:0]        max2_reg, max2b_reg;

    logic [SUM_W-1:0]        sum_reg;
    logic signed [DOT_W-1:0] dot_reg, cross_reg;

    logic [RAD_W-1:0] rad_reg;
    rbr_vec_t         vec_reg;

    logic keep_in;
    logic over;
    logic signed [ROT_W-1:0] dot_w, cross_w;
    rbr_vec_t vec_next;

    assign keep_in = in_valid & in_user[USR_HAS_ID] & ~in_user[USR_FOUND];
    assign over    = sum_reg > SUM_W'(max2b_reg);
    assign dot_w   = ROT_W'(dot_reg);
    assign cross_w = ROT_W'(cross_reg);

    // Quadrant turn so that x is never negative
    always_comb begin
        vec_next.x    = dot_w;
        vec_next.y    = cross_w;
        vec_next.z    = '0;
        vec_next.zero = (dot_reg == '0) && (cross_reg == '0);
        if (dot_reg < 0) begin
            if (cross_reg >= 0) begin
                vec_next.x = cross_w;
                vec_next.y = -dot_w;
                vec_next.z = Z_QUARTER;
            end else begin
                vec_next.x = -cross_w;
                vec_next.y = dot_w;
                vec_next.z = -Z_QUARTER;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= keep_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg & ~over;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= DIFF_W'($signed(in_data[OFS_TX +: COORD_BITS]))
                    - DIFF_W'($signed(in_data[OFS_OX +: COORD_BITS]));
            dy_reg <= DIFF_W'($signed(in_data[OFS_TY +: COORD_BITS]))
                    - DIFF_W'($signed(in_data[OFS_OY +: COORD_BITS]));
            dz_reg <= DIFF_W'($signed(in_data[OFS_TZ +: COORD_BITS]))
                    - DIFF_W'($signed(in_data[OFS_OZ +: COORD_BITS]));
            hx_reg   <= $signed(in_data[OFS_HX +: HEAD_W]);
            hy_reg   <= $signed(in_data[OFS_HY +: HEAD_W]);
            tag1_reg <= in_data[OFS_TAG +: TAG_W];

            sqx_reg  <= dx_reg * dx_reg;
            sqy_reg  <= dy_reg * dy_reg;
            sqz_reg  <= dz_reg * dz_reg;
            pxx_reg  <= PROD_W'(hx_reg) * PROD_W'(dx_reg);
            pyy_reg  <= PROD_W'(hy_reg) * PROD_W'(dy_reg);
            pxy_reg  <= PROD_W'(hx_reg) * PROD_W'(dy_reg);
            pyx_reg  <= PROD_W'(hy_reg) * PROD_W'(dx_reg);
            max2_reg <= MAX2_W'(max_distance) * MAX2_W'(max_distance);
            tag2_reg <= tag1_reg;

            sum_reg   <= SUM_W'($unsigned(sqx_reg)) + SUM_W'($unsigned(sqy_reg))
                       + SUM_W'($unsigned(sqz_reg));
            dot_reg   <= DOT_W'(pxx_reg) + DOT_W'(pyy_reg);
            cross_reg <= DOT_W'(pxy_reg) - DOT_W'(pyx_reg);
            max2b_reg <= max2_reg;
            tag3_reg  <= tag2_reg;

            rad_reg  <= RAD_W'(sum_reg);
            vec_reg  <= vec_next;
            tag4_reg <= tag3_reg;
        end
    end

    assign out_ctrl.valid = v4_reg;
    assign out_ctrl.tag   = tag4_reg;
    assign out_rad        = rad_reg;
    assign out_vec        = vec_reg;

endmodule
`default_nettype wire

>>> rtl/rbr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rbr_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [rbr_pkg::RAD_W-1:0]  rad,
    output logic [rbr_pkg::RANGE_W-1:0]     root
);
    import rbr_pkg::*;

    logic [RAD_W-1:0]   rad_reg  [SQRT_LAT+1];
    logic [REM_W-1:0]   rem_reg  [SQRT_LAT+1];
    logic [RANGE_W-1:0] root_reg [SQRT_LAT+1];

    assign rad_reg[0]  = rad;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    // One restoring step per stage
    for (genvar j = 0; j < SQRT_LAT; j++) begin : g_step
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        assign rem_sh = {rem_reg[j][REM_W-3:0], rad_reg[j][RAD_W-1 -: 2]};
        assign trial  = {root_reg[j], 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j+1] <= {rad_reg[j][RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg[j+1]  <= rem_sh - trial;
                    root_reg[j+1] <= {root_reg[j][RANGE_W-2:0], 1'b1};
                end else begin
                    rem_reg[j+1]  <= rem_sh;
                    root_reg[j+1] <= {root_reg[j][RANGE_W-2:0], 1'b0};
                end
            end
        end
    end

    // Delay to match the bearing path
    if (SQRT_PAD > 0) begin : g_pad
        logic [RANGE_W-1:0] pad_reg [SQRT_PAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                pad_reg[0] <= root_reg[SQRT_LAT];
                for (int k = 1; k < SQRT_PAD; k++) pad_reg[k] <= pad_reg[k-1];
            end
        end
        assign root = pad_reg[SQRT_PAD-1];
    end else begin : g_nopad
        assign root = root_reg[SQRT_LAT];
    end

endmodule
`default_nettype wire

>>> rtl/rbr_norm.sv
// Scales the bearing vector so its larger magnitude lies in [2^30, 2^31).
`default_nettype none
module rbr_norm (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  rbr_pkg::rbr_vec_t              in_vec,
    output logic signed [rbr_pkg::CW-1:0]  out_x,
    output logic signed [rbr_pkg::CW-1:0]  out_y,
    output logic signed [rbr_pkg::ZW-1:0]  out_z,
    output logic                           out_zero
);
    import rbr_pkg::*;

    logic signed [NORM_W-1:0] x_reg [NORM_STEPS+1];
    logic signed [NORM_W-1:0] y_reg [NORM_STEPS+1];
    logic [NORM_W-1:0]        m_reg [NORM_STEPS+1];
    logic signed [ZW-1:0]     z_reg [NORM_STEPS+1];
    logic                     zero_reg [NORM_STEPS+1];

    logic [ROT_W-1:0] ax, ay, m0;

    assign ax = (in_vec.x < 0) ? ROT_W'(-in_vec.x) : ROT_W'(in_vec.x);
    assign ay = (in_vec.y < 0) ? ROT_W'(-in_vec.y) : ROT_W'(in_vec.y);
    assign m0 = (ax > ay) ? ax : ay;

    // Exact pre-scale by 2^30, then floor shifts bring the magnitude down
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= NORM_W'(in_vec.x) <<< NORM_PRE;
            y_reg[0]    <= NORM_W'(in_vec.y) <<< NORM_PRE;
            m_reg[0]    <= NORM_W'(m0) << NORM_PRE;
            z_reg[0]    <= in_vec.z;
            zero_reg[0] <= in_vec.zero;
        end
    end

    // Shift only while the shifted magnitude stays at or above 2^30
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_shift
        localparam int SH = norm_shift(j);
        logic big;
        assign big = |m_reg[j][NORM_W-1:30+SH];
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[j+1]    <= big ? (x_reg[j] >>> SH) : x_reg[j];
                y_reg[j+1]    <= big ? (y_reg[j] >>> SH) : y_reg[j];
                m_reg[j+1]    <= big ? (m_reg[j] >> SH) : m_reg[j];
                z_reg[j+1]    <= z_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    assign out_x    = CW'(x_reg[NORM_STEPS]);
    assign out_y    = CW'(y_reg[NORM_STEPS]);
    assign out_z    = z_reg[NORM_STEPS];
    assign out_zero = zero_reg[NORM_STEPS];

endmodule
`default_nettype wire

>>> rtl/rbr_cordic.sv
// Vectoring CORDIC stages, rounding and clamping of the bearing.
`default_nettype none
module rbr_cordic (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [rbr_pkg::CW-1:0] in_x,
    input  wire logic signed [rbr_pkg::CW-1:0] in_y,
    input  wire logic signed [rbr_pkg::ZW-1:0] in_z,
    input  wire logic                          in_zero,
    output logic signed [rbr_pkg::BEAR_W-1:0]  bearing
);
    import rbr_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 zero_reg [CORDIC_STEPS+1];

    assign x_reg[0]    = in_x;
    assign y_reg[0]    = in_y;
    assign z_reg[0]    = in_z;
    assign zero_reg[0] = in_zero;

    // Rotate towards the x axis, one step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [CW-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + $signed(ATAN_UNITS[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - $signed(ATAN_UNITS[i]);
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Round to centidegrees and clamp
    logic signed [ZW-1:0]     z_rnd;
    logic signed [BEAR_W-1:0] r;
    logic signed [BEAR_W-1:0] bear_next;
    logic signed [BEAR_W-1:0] bear_reg;

    assign z_rnd = z_reg[CORDIC_STEPS] + Z_ROUND;
    assign r     = BEAR_W'(z_rnd >>> ANGLE_SCALE_LOG);

    always_comb begin
        priority if (zero_reg[CORDIC_STEPS]) bear_next = '0;
        else if (r > BEAR_MAX)               bear_next = BEAR_MAX;
        else if (r < BEAR_MIN)               bear_next = BEAR_MIN;
        else                                 bear_next = r;
    end

    always_ff @(posedge aclk) begin
        if (en) bear_reg <= bear_next;
    end

    // Delay to match the range path
    if (ANGLE_PAD > 0) begin : g_pad
        logic signed [BEAR_W-1:0] pad_reg [ANGLE_PAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                pad_reg[0] <= bear_reg;
                for (int k = 1; k < ANGLE_PAD; k++) pad_reg[k] <= pad_reg[k-1];
            end
        end
        assign bearing = pad_reg[ANGLE_PAD-1];
    end else begin : g_nopad
        assign bearing = bear_reg;
    end

endmodule
`default_nettype wire

>>> rtl/relative_bearing_and_range_top.sv
// Top level of the relative bearing and range block.
//
// Input stream s_*: one target per transfer with the observer position
// and heading. Targets without an identifier, already found, or farther
// than max_distance give no result; every other target gives one
// result transfer on m_* with tag, range (floor of the 3D distance) and
// the bearing from the heading in centidegrees, right positive.
// cfg_*: write of max_distance, always ready; the user must write it
// only while idle, the block does not enforce it. Throughput: one target
// per cycle unless the receiver stalls. Stages: 4 front, then the longer
// of the square root (one stage per root bit, 25) and the bearing path
// (scaling 7, CORDIC 16, rounding 1). The whole pipeline advances while
// the output register is empty or taken; when the receiver stalls with
// a result waiting, every stage holds and s_tready drops. Reset clears
// all valid bits and loads max_distance with 1000000.
`default_nettype none
module relative_bearing_and_range_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // observer_x, observer_y, observer_z, heading_x, heading_y,
    // target_x, target_y, target_z, target_tag
    input  wire logic [rbr_pkg::S_TDATA_W-1:0] s_tdata,
    // has_identifier, already_found
    input  wire logic [rbr_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // result_tag, range_cm, bearing_centideg
    output logic [rbr_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rbr_pkg::MAXD_W-1:0]    cfg_data
);
    import rbr_pkg::*;

    logic en;
    logic [MAXD_W-1:0] max_distance_reg;

    rbr_ctrl_t         front_ctrl;
    logic [RAD_W-1:0]  front_rad;
    rbr_vec_t          front_vec;
    logic signed [CW-1:0] nx, ny;
    logic signed [ZW-1:0] nz;
    logic                 nzero;
    logic [RANGE_W-1:0]       root;
    logic signed [BEAR_W-1:0] bearing;

    rbr_ctrl_t ctrl_reg [BACK_LAT];

    assign en        = ~ctrl_reg[BACK_LAT-1].valid | m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Distance limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) max_distance_reg <= MAXD_W'(MAXD_RESET);
        else if (cfg_valid) max_distance_reg <= cfg_data;
    end

    rbr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .in_data      (s_tdata),
        .in_user      (s_tuser),
        .max_distance (max_distance_reg),
        .out_ctrl     (front_ctrl),
        .out_rad      (front_rad),
        .out_vec      (front_vec)
    );

    rbr_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (front_rad),
        .root (root)
    );

    rbr_norm u_norm (
        .aclk     (aclk),
        .en       (en),
        .in_vec   (front_vec),
        .out_x    (nx),
        .out_y    (ny),
        .out_z    (nz),
        .out_zero (nzero)
    );

    rbr_cordic u_cordic (
        .aclk    (aclk),
        .en      (en),
        .in_x    (nx),
        .in_y    (ny),
        .in_z    (nz),
        .in_zero (nzero),
        .bearing (bearing)
    );

    // Valid bits and tags alongside the arithmetic
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < BACK_LAT; k++) ctrl_reg[k].valid <= 1'b0;
        end else if (en) begin
            ctrl_reg[0] <= front_ctrl;
            for (int k = 1; k < BACK_LAT; k++) ctrl_reg[k] <= ctrl_reg[k-1];
        end
    end

    assign m_tvalid = ctrl_reg[BACK_LAT-1].valid;
    assign m_tdata  = M_TDATA_W'({bearing, root, ctrl_reg[BACK_LAT-1].tag});

endmodule
`default_nettype wire

>>> rtl/rbr_checker.sv
// Port-level checks of the relative bearing and range block, and their binding.
`default_nettype none
module rbr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rbr_pkg::M_TDATA_W-1:0] m_tdata
);
    import rbr_pkg::*;

    logic signed [BEAR_W-1:0] bear;
    assign bear = $signed(m_tdata[TAG_W + RANGE_W +: BEAR_W]);

    // No result straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input is taken whenever the output side can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

    // Bearing stays within half a turn
    a_bear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (bear <= BEAR_MAX) && (bear >= BEAR_MIN))
        else $error("bearing out of range");

endmodule

bind relative_bearing_and_range_top rbr_checker u_rbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the relative bearing and range block: random target stream, own predictor.
module testbench;
    import rbr_pkg::*;

    localparam int LATENCY   = 29;
    localparam int WDOG_MAX  = 20000;
    localparam int MAX_SHOWN = 10;

    // One target as offered on the input stream
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ox, oy, oz;
        logic signed [HEAD_W-1:0]     hx, hy;
        logic signed [COORD_BITS-1:0] tx, ty, tz;
        logic [TAG_W-1:0]             tag;
        logic                         has_id, found;
    } target_t;

    // One report as it leaves the block
    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic [RANGE_W-1:0]       range_cm;
        logic signed [BEAR_W-1:0] bearing;
    } report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [MAXD_W-1:0] cfg_data = '0;

    relative_bearing_and_range_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Bench-side copy of the range limit
    logic [MAXD_W-1:0] range_limit;

    target_t pending_targets[$];
    report_t expected_reports[$];
    int  mismatches = 0;
    int  reports_seen = 0;
    int  targets_sent = 0;
    int  idle_pct_src = 20;
    int  idle_pct_snk = 20;
    bit  sink_hold = 1'b0;
    bit  hold_go = 1'b0;
    bit  src_pause = 1'b0;
    int  wdog = 0;
    bit  timed_out = 1'b0;

    localparam longint ATAN_UNITS_TB [24] = '{
        18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
        91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
        358, 179, 90, 45, 22, 11, 6, 3
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Floor shift right for signed values
    function automatic longint floor_shr(input longint v, input int s);
        floor_shr = v >>> s;
    endfunction

    // CORDIC vectoring of (x, y) to centidegrees
    function automatic longint cordic_angle(input longint x_in, input longint y_in);
        longint x, y, z, t, xs, ys, m, r;
        x = x_in; y = y_in; z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 9000 * 4096;
            end else begin
                t = x; x = -y; y = t; z = -9000 * 4096;
            end
        end
        m = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        while (m < (64'sd1 << 30)) begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        while (m >= (64'sd1 << 31)) begin
            x = floor_shr(x, 1); y = floor_shr(y, 1); m = m >> 1;
        end
        for (int i = 0; i < ATAN_ITERATIONS && i < 24; i++) begin
            xs = floor_shr(x, i); ys = floor_shr(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_UNITS_TB[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_UNITS_TB[i];
            end
        end
        r = floor_shr(z + 2048, 12);
        if (r > 18000) r = 18000;
        if (r < -18000) r = -18000;
        return r;
    endfunction

    // Integer square root, floor
    function automatic longint isqrt(input longint s);
        longint r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'sd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    // Expected report for one target, if any
    function automatic void predict_report(input target_t t);
        longint dx, dy, dz, hx, hy, sq, lim;
        report_t r;
        if (!t.has_id || t.found) return;
        dx = longint'(t.tx) - longint'(t.ox);
        dy = longint'(t.ty) - longint'(t.oy);
        dz = longint'(t.tz) - longint'(t.oz);
        hx = longint'(t.hx); hy = longint'(t.hy);
        sq = dx * dx + dy * dy + dz * dz;
        lim = longint'(range_limit);
        if (sq > lim * lim) return;
        r.tag = t.tag;
        r.range_cm = RANGE_W'(isqrt(sq));
        r.bearing = BEAR_W'(cordic_angle(hx * dx + hy * dy, hx * dy - hy * dx));
        expected_reports.push_back(r);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_target(input target_t t);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OFS_OX +: COORD_BITS] = t.ox;
        d[OFS_OY +: COORD_BITS] = t.oy;
        d[OFS_OZ +: COORD_BITS] = t.oz;
        d[OFS_HX +: HEAD_W]     = t.hx;
        d[OFS_HY +: HEAD_W]     = t.hy;
        d[OFS_TX +: COORD_BITS] = t.tx;
        d[OFS_TY +: COORD_BITS] = t.ty;
        d[OFS_TZ +: COORD_BITS] = t.tz;
        d[OFS_TAG +: TAG_W]     = t.tag;
        return d;
    endfunction

    // Input driver: one transfer per accepted target, predicted with the limit in force
    always @(posedge aclk) begin
        target_t t;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_report(pending_targets.pop_front());
                targets_sent <= targets_sent + 1;
            end
            if (s_tvalid && !s_tready) begin
                // keep offering the same item
            end else if (pending_targets.size() > 0 && !src_pause &&
                         $urandom_range(99) >= idle_pct_src) begin
                t = pending_targets[0];
                s_tdata  <= pack_target(t);
                s_tuser  <= {t.found, t.has_id};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor and receiver stalls
    always @(posedge aclk) begin
        report_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[0 +: TAG_W], m_tdata[TAG_W +: RANGE_W],
                        m_tdata[TAG_W+RANGE_W +: BEAR_W]};
                reports_seen <= reports_seen + 1;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected report tag=%0d range=%0d bearing=%0d",
                                 got.tag, got.range_cm, got.bearing);
                end else begin
                    want = expected_reports.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"mismatch: exp tag=%0d range=%0d bearing=%0d,",
                                      " got tag=%0d range=%0d bearing=%0d"},
                                     want.tag, want.range_cm, want.bearing,
                                     got.tag, got.range_cm, got.bearing);
                    end
                end
            end
            m_tready <= !sink_hold && ($urandom_range(99) >= idle_pct_snk);
        end
    end

    // Long receiver hold, counted here while the sender keeps offering
    initial begin
        int hold;
        wait (hold_go);
        sink_hold = 1'b1;
        hold = 0;
        while (hold < 200) begin
            @(posedge aclk);
            hold++;
        end
        sink_hold = 1'b0;
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (wdog >= WDOG_MAX && !timed_out) begin
                timed_out <= 1'b1;
                $display("watchdog: no transfer for %0d cycles", WDOG_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(3))
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($signed($urandom_range(4000)) - 2000);
            2: return $urandom_range(1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                       : {1'b1, {(COORD_BITS-1){1'b0}}};
            default: return COORD_BITS'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    // Mostly reportable targets near the observer, some noise
    function automatic target_t rand_target();
        target_t t;
        t.ox = rand_coord(); t.oy = rand_coord(); t.oz = rand_coord();
        if ($urandom_range(99) < 70) begin
            t.tx = t.ox + COORD_BITS'($signed($urandom_range(2000000)) - 1000000);
            t.ty = t.oy + COORD_BITS'($signed($urandom_range(2000000)) - 1000000);
            t.tz = t.oz + COORD_BITS'($signed($urandom_range(200000)) - 100000);
        end else begin
            t.tx = rand_coord(); t.ty = rand_coord(); t.tz = rand_coord();
        end
        t.hx = HEAD_W'($urandom); t.hy = HEAD_W'($urandom);
        if ($urandom_range(9) == 0) t.hx = '0;
        if ($urandom_range(9) == 0) t.hy = '0;
        t.tag = TAG_W'($urandom);
        t.has_id = $urandom_range(99) < 90;
        t.found  = $urandom_range(99) < 10;
        return t;
    endfunction

    function automatic target_t make_target(input int ox, oy, oz, hx, hy, tx, ty, tz,
                                            input int tag);
        target_t t;
        t.ox = COORD_BITS'(ox); t.oy = COORD_BITS'(oy); t.oz = COORD_BITS'(oz);
        t.hx = HEAD_W'(hx); t.hy = HEAD_W'(hy);
        t.tx = COORD_BITS'(tx); t.ty = COORD_BITS'(ty); t.tz = COORD_BITS'(tz);
        t.tag = TAG_W'(tag);
        t.has_id = 1'b1; t.found = 1'b0;
        return t;
    endfunction

    task automatic drain();
        while (pending_targets.size() > 0 || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [MAXD_W-1:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        range_limit = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        target_t t;
        range_limit = MAXD_W'(MAXD_RESET);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: skip flags, zero offset, zero heading, quadrants, extremes
        t = make_target(0, 0, 0, 16384, 0, 100, 0, 0, 1); pending_targets.push_back(t);
        t.has_id = 1'b0; pending_targets.push_back(t);
        t.has_id = 1'b1; t.found = 1'b1; pending_targets.push_back(t);
        t.has_id = 1'b0; pending_targets.push_back(t);
        pending_targets.push_back(make_target(5, 5, 5, 16384, 0, 5, 5, 900, 2));
        pending_targets.push_back(make_target(0, 0, 0, 0, 0, 300, 400, 0, 3));
        pending_targets.push_back(make_target(0, 0, 0, 16384, 0, -100, 0, 0, 4));
        pending_targets.push_back(make_target(0, 0, 0, 16384, 0, -100, -1, 0, 5));
        pending_targets.push_back(make_target(0, 0, 0, 16384, 0, 0, 100, 0, 6));
        pending_targets.push_back(make_target(0, 0, 0, 16384, 0, 0, -100, 0, 7));
        pending_targets.push_back(make_target(0, 0, 0, -32768, -32768, 70, -3, 1, 8));
        pending_targets.push_back(make_target(0, 0, 0, 32767, 32767, 1, 1, 1, 65535));
        pending_targets.push_back(make_target(0, 0, 0, 16384, 0, 1000000, 0, 0, 9));
        pending_targets.push_back(make_target(0, 0, 0, 16384, 0, 1000001, 0, 0, 10));
        pending_targets.push_back(make_target(0, 0, 0, 16384, 0, 600000, 800000, 0, 11));
        write_limit(MAXD_W'(29058990));
        pending_targets.push_back(make_target(-8388608, -8388608, -8388608, 1, -1,
                                              8388607, 8388607, 8388607, 12));
        pending_targets.push_back(make_target(8388607, 8388607, 8388607, -32768, 32767,
                                              -8388608, -8388608, -8388608, 13));
        pending_targets.push_back(make_target(8388607, 0, 0, 0, 32767, -8388608, 0, 0, 14));
        write_limit('0);
        pending_targets.push_back(make_target(7, 7, 7, 100, 100, 7, 7, 7, 15));
        pending_targets.push_back(make_target(7, 7, 7, 100, 100, 8, 7, 7, 16));
        write_limit({MAXD_W{1'b1}});
        pending_targets.push_back(make_target(-8388608, 0, 0, 1, 0, 8388607, 0, 0, 17));

        // Random phases with different limits and idling
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_limit(MAXD_W'(MAXD_RESET));
                1: write_limit(MAXD_W'(29058990));
                2: write_limit(MAXD_W'($urandom_range(2000000)));
                3: write_limit(MAXD_W'(500000));
                4: write_limit(MAXD_W'(29058990));
                default: write_limit(MAXD_W'(1500000));
            endcase
            idle_pct_src = (ph == 4) ? 0 : 20;
            idle_pct_snk = (ph == 4) ? 0 : 20;
            for (int i = 0; i < 240; i++) pending_targets.push_back(rand_target());
            if (ph == 2) begin
                // long receiver hold while input keeps coming
                repeat (20) @(posedge aclk);
                hold_go = 1'b1;
            end
            if (ph == 3) begin
                // source pause until everything is back
                while (pending_targets.size() > 120) @(posedge aclk);
                src_pause = 1'b1;
                while (expected_reports.size() > 0) @(posedge aclk);
                src_pause = 1'b0;
            end
        end
        drain();

        $display("covered %0d targets, %0d reports, limits zero to full scale",
                 targets_sent, reports_seen);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> relative_bearing_and_range_top.f
rtl/rbr_pkg.sv
rtl/rbr_front.sv
rtl/rbr_sqrt.sv
rtl/rbr_norm.sv
rtl/rbr_cordic.sv
rtl/relative_bearing_and_range_top.sv
rtl/rbr_checker.sv
bench/testbench.sv
